// ===== rtl/iso6709_coordinate_parser_macros.svh =====
// Assertion macros used by the coordinate parser checker.
`ifndef ISO6709_COORDINATE_PARSER_MACROS_SVH
`define ISO6709_COORDINATE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ICP_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ICP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/icp_pkg.sv =====
// Types and constants for the ISO 6709 coordinate parser.
package icp_pkg;

    localparam int CH_W      = 8;
    localparam int LAT_W     = 20;
    localparam int LON_W     = 23;
    localparam int LAT_MAG_W = LAT_W - 1;
    localparam int LON_MAG_W = LON_W - 1;
    localparam int CNT_W     = 3;

    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

    localparam int SEC_PER_MIN = 60;
    localparam int SEC_PER_DEG = 3600;

    localparam int LAT_ARCSEC_MAX = 362439;
    localparam int LON_ARCSEC_MAX = 3602439;

    typedef enum logic [4:0] {
        PH_SIGN = 5'b00001,
        PH_LAT  = 5'b00010,
        PH_LON  = 5'b00100,
        PH_DONE = 5'b01000,
        PH_BAD  = 5'b10000
    } phase_t;

endpackage

// ===== rtl/iso6709_coordinate_parser.sv =====
// Top level: ISO 6709 coordinate string parser, one character per word.
//
//  channel | direction | payload                                 | word
//  --------+-----------+-----------------------------------------+------------------
//  s_      | in        | s_ch[7:0], s_last                       | one character
//  m_      | out       | m_valid_res, m_lat_arcsec, m_lon_arcsec | one parsed string
//
// One character is taken per cycle while s_ready is high; the result word is
// registered: the word with s_last goes to the input register, then the result
// to the result register. Reset (aresetn low, synchronous) empties both
// registers and returns the parser to waiting for the leading sign.
// While a result waits on m_ready, characters without s_last keep flowing;
// a character with s_last waits in the input register until the result slot frees.
module iso6709_coordinate_parser
    import icp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CH_W-1:0]         s_ch,
    input  logic                    s_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_valid_res,
    output logic signed [LAT_W-1:0] m_lat_arcsec,
    output logic signed [LON_W-1:0] m_lon_arcsec
);

    // input register
    logic            in_vld_reg, in_vld_next;
    logic [CH_W-1:0] ch_reg;
    logic            last_reg;

    // parser state
    phase_t          phase_reg, phase_next, phase_step;
    logic            lat_neg_reg, lat_neg_next;
    logic            lon_neg_reg, lon_neg_next;
    logic [CNT_W-1:0] lat_cnt_reg, lat_cnt_next;
    logic [CNT_W-1:0] lon_cnt_reg, lon_cnt_next;
    logic            lat_odd_reg, lat_odd_next;
    logic            lon_odd_reg, lon_odd_next;
    logic [6:0]      lat_deg_reg, lat_deg_next;
    logic [6:0]      lat_min_reg, lat_min_next;
    logic [6:0]      lat_sec_reg, lat_sec_next;
    logic [9:0]      lon_deg_reg, lon_deg_next;
    logic [6:0]      lon_min_reg, lon_min_next;
    logic [6:0]      lon_sec_reg, lon_sec_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic                    res_ok_reg;
    logic signed [LAT_W-1:0] lat_res_reg;
    logic signed [LON_W-1:0] lon_res_reg;

    logic            s_fire, advance, ok;
    logic            is_digit, is_sign;
    logic [3:0]      digit;
    logic [6:0]      lat_deg_eff, lat_min_eff, lat_sec_eff, lon_min_eff, lon_sec_eff;
    logic [9:0]      lon_deg_eff;
    logic [LAT_MAG_W-1:0] lat_mag;
    logic [LON_MAG_W-1:0] lon_mag;
    logic [LAT_W-1:0] lat_val;
    logic [LON_W-1:0] lon_val;

    // a last word only moves on when the result slot is free or being drained
    assign advance = in_vld_reg && (!last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_sign  = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS);
    assign digit    = ch_reg[3:0];

    // partial groups count as zero
    assign lat_deg_eff = (lat_cnt_reg >= 3'd2) ? lat_deg_reg : '0;
    assign lat_min_eff = (lat_cnt_reg >= 3'd4) ? lat_min_reg : '0;
    assign lat_sec_eff = (lat_cnt_reg >= 3'd6) ? lat_sec_reg : '0;
    assign lon_deg_eff = (lon_cnt_reg >= 3'd3) ? lon_deg_reg : '0;
    assign lon_min_eff = (lon_cnt_reg >= 3'd5) ? lon_min_reg : '0;
    assign lon_sec_eff = (lon_cnt_reg >= 3'd7) ? lon_sec_reg : '0;

    // A string can only end valid on a non-digit step, so digit state is
    // already final in the registers when the last word is processed.
    assign lat_mag = LAT_MAG_W'(lat_deg_eff) * LAT_MAG_W'(SEC_PER_DEG)
                   + LAT_MAG_W'(lat_min_eff) * LAT_MAG_W'(SEC_PER_MIN)
                   + LAT_MAG_W'(lat_sec_eff);
    assign lon_mag = LON_MAG_W'(lon_deg_eff) * LON_MAG_W'(SEC_PER_DEG)
                   + LON_MAG_W'(lon_min_eff) * LON_MAG_W'(SEC_PER_MIN)
                   + LON_MAG_W'(lon_sec_eff);
    assign lat_val = lat_neg_reg ? (LAT_W'(0) - {1'b0, lat_mag}) : {1'b0, lat_mag};
    assign lon_val = lon_neg_reg ? (LON_W'(0) - {1'b0, lon_mag}) : {1'b0, lon_mag};

    always_comb begin
        phase_step   = phase_reg;
        lat_neg_next = lat_neg_reg;
        lon_neg_next = lon_neg_reg;
        lat_cnt_next = lat_cnt_reg;
        lon_cnt_next = lon_cnt_reg;
        lat_odd_next = lat_odd_reg;
        lon_odd_next = lon_odd_reg;
        lat_deg_next = lat_deg_reg;
        lat_min_next = lat_min_reg;
        lat_sec_next = lat_sec_reg;
        lon_deg_next = lon_deg_reg;
        lon_min_next = lon_min_reg;
        lon_sec_next = lon_sec_reg;

        case (phase_reg)
            PH_SIGN: begin
                if (is_sign) begin
                    lat_neg_next = (ch_reg == CH_MINUS);
                    phase_step   = PH_LAT;
                end else begin
                    phase_step = PH_BAD;
                end
            end
            PH_LAT: begin
                if (is_sign) begin
                    lon_neg_next = (ch_reg == CH_MINUS);
                    phase_step   = PH_LON;
                end else if (is_digit) begin
                    if (lat_cnt_reg < 3'd2)
                        lat_deg_next = 7'(lat_deg_reg * 7'd10 + {3'b0, digit});
                    else if (lat_cnt_reg < 3'd4)
                        lat_min_next = 7'(lat_min_reg * 7'd10 + {3'b0, digit});
                    else if (lat_cnt_reg < 3'd6)
                        lat_sec_next = 7'(lat_sec_reg * 7'd10 + {3'b0, digit});
                    if (lat_cnt_reg != 3'd7)
                        lat_cnt_next = lat_cnt_reg + 3'd1;
                    lat_odd_next = !lat_odd_reg;
                end else begin
                    phase_step = PH_BAD;
                end
            end
            PH_LON: begin
                if (is_digit) begin
                    if (lon_cnt_reg < 3'd3)
                        lon_deg_next = 10'(lon_deg_reg * 10'd10 + {6'b0, digit});
                    else if (lon_cnt_reg < 3'd5)
                        lon_min_next = 7'(lon_min_reg * 7'd10 + {3'b0, digit});
                    else if (lon_cnt_reg < 3'd7)
                        lon_sec_next = 7'(lon_sec_reg * 7'd10 + {3'b0, digit});
                    if (lon_cnt_reg != 3'd7)
                        lon_cnt_next = lon_cnt_reg + 3'd1;
                    lon_odd_next = !lon_odd_reg;
                end else if (ch_reg == CH_NUL) begin
                    phase_step = PH_BAD;
                end else begin
                    phase_step = PH_DONE;
                end
            end
            PH_DONE: phase_step = PH_DONE;
            default: phase_step = PH_BAD;
        endcase

        ok = (phase_step == PH_DONE) && !lat_odd_reg && lon_odd_reg;
        phase_next = phase_step;

        // end of string: back to the reset state
        if (last_reg) begin
            phase_next   = PH_SIGN;
            lat_neg_next = 1'b0;
            lon_neg_next = 1'b0;
            lat_cnt_next = '0;
            lon_cnt_next = '0;
            lat_odd_next = 1'b0;
            lon_odd_next = 1'b0;
            lat_deg_next = '0;
            lat_min_next = '0;
            lat_sec_next = '0;
            lon_deg_next = '0;
            lon_min_next = '0;
            lon_sec_next = '0;
        end
    end

    always_comb begin
        if (s_fire)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        m_valid_next = (m_valid_reg && !m_ready) || (advance && last_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            phase_reg   <= PH_SIGN;
            lat_neg_reg <= 1'b0;
            lon_neg_reg <= 1'b0;
            lat_cnt_reg <= '0;
            lon_cnt_reg <= '0;
            lat_odd_reg <= 1'b0;
            lon_odd_reg <= 1'b0;
            lat_deg_reg <= '0;
            lat_min_reg <= '0;
            lat_sec_reg <= '0;
            lon_deg_reg <= '0;
            lon_min_reg <= '0;
            lon_sec_reg <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
            if (advance) begin
                phase_reg   <= phase_next;
                lat_neg_reg <= lat_neg_next;
                lon_neg_reg <= lon_neg_next;
                lat_cnt_reg <= lat_cnt_next;
                lon_cnt_reg <= lon_cnt_next;
                lat_odd_reg <= lat_odd_next;
                lon_odd_reg <= lon_odd_next;
                lat_deg_reg <= lat_deg_next;
                lat_min_reg <= lat_min_next;
                lat_sec_reg <= lat_sec_next;
                lon_deg_reg <= lon_deg_next;
                lon_min_reg <= lon_min_next;
                lon_sec_reg <= lon_sec_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ch_reg   <= s_ch;
            last_reg <= s_last;
        end
        if (advance && last_reg) begin
            res_ok_reg  <= ok;
            lat_res_reg <= ok ? lat_val : '0;
            lon_res_reg <= ok ? lon_val : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_valid_res  = res_ok_reg;
    assign m_lat_arcsec = lat_res_reg;
    assign m_lon_arcsec = lon_res_reg;

endmodule

// ===== rtl/icp_checker.sv =====
// Port-level checker for the coordinate parser, bound to the top level.
`include "iso6709_coordinate_parser_macros.svh"

module icp_checker
    import icp_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [CH_W-1:0]         s_ch,
    input logic                    s_last,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_valid_res,
    input logic signed [LAT_W-1:0] m_lat_arcsec,
    input logic signed [LON_W-1:0] m_lon_arcsec
);

    // coming out of reset the result slot is empty
    `ICP_ASSERT(a_reset_empty, aclk, aresetn, $rose(aresetn), !m_valid, "result word right after reset")

    // a failed string carries zero coordinates
    `ICP_ASSERT(a_invalid_zero, aclk, aresetn, m_valid && !m_valid_res, (m_lat_arcsec == '0) && (m_lon_arcsec == '0), "invalid word with nonzero coordinates")

    // digit groups cap the magnitude
    `ICP_ASSERT(a_coord_range, aclk, aresetn, m_valid, (m_lat_arcsec >= -LAT_ARCSEC_MAX) && (m_lat_arcsec <= LAT_ARCSEC_MAX) && (m_lon_arcsec >= -LON_ARCSEC_MAX) && (m_lon_arcsec <= LON_ARCSEC_MAX), "coordinate out of range")

    `ICP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_valid_res) && $stable(m_lat_arcsec) && $stable(m_lon_arcsec), "stalled result word changed")

endmodule

bind iso6709_coordinate_parser icp_checker u_icp_checker (.*);
